// File: rtl/core/pce_pkg.sv
// Shared types and constants for the prefix-code byte encoder.
package pce_pkg;

  localparam int SymW   = 8;
  localparam int InLenW = 6;
  localparam int InWordW = 32;
  localparam int ByteW  = 8;
  localparam int KindW  = 2;
  localparam int InDataW = 48;

  localparam logic [2:0] EmptyPos = 3'd7;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic tbl_wr;      // write table entry from input transfer
    logic tbl_rd;      // read table entry for input symbol
    logic code_ld;     // load packer shift register from table read data
    logic pack_step;   // move one chunk of code bits into the pending byte
    logic flush_pend;  // emit partial pending byte
    logic emit_mark;   // emit marker byte and empty the packer
  } pce_cmd_t;

  typedef struct packed {
    logic code_done;   // no code bits left
    logic last_step;   // next step drains the remaining code bits
    logic byte_full;   // next step completes a byte
    logic pend_empty;  // packer holds no bits
    logic slot_free;   // output register can take a byte this cycle
  } pce_sts_t;

endpackage

// File: rtl/core/pce_ctrl.sv
// Controller state machine of the prefix-code byte encoder.
module pce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_kind_i,
  output logic              in_ready_o,
  input  pce_pkg::pce_sts_t sts_i,
  output pce_pkg::pce_cmd_t cmd_o
);
  import pce_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PACK,
    ST_FLUSH,
    ST_MARK
  } state_e;

  state_e state_q, state_d;
  kind_e  kind;
  logic   accept;

  assign kind       = kind_e'(in_kind_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOAD: cmd_o.tbl_wr = 1'b1;
            KIND_ENCODE: begin
              cmd_o.tbl_rd = 1'b1;
              state_d      = ST_LOOKUP;
            end
            KIND_FINISH: state_d = ST_FLUSH;
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd_o.code_ld = 1'b1;
        state_d       = ST_PACK;
      end
      ST_PACK: begin
        if (sts_i.code_done) begin
          state_d = ST_IDLE;
        end else if (sts_i.slot_free || !sts_i.byte_full) begin
          cmd_o.pack_step = 1'b1;
          if (sts_i.last_step) state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.pend_empty) begin
          state_d = ST_MARK;
        end else if (sts_i.slot_free) begin
          cmd_o.flush_pend = 1'b1;
          state_d          = ST_MARK;
        end
      end
      ST_MARK: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_mark = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/pce_dpath.sv
// Datapath of the prefix-code byte encoder: code table, bit packer, output register.
module pce_dpath #(
  parameter int CodeW = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pce_pkg::pce_cmd_t            cmd_i,
  output pce_pkg::pce_sts_t            sts_o,
  input  logic [pce_pkg::SymW-1:0]     symbol_i,
  input  logic [pce_pkg::InLenW-1:0]   code_length_i,
  input  logic [pce_pkg::InWordW-1:0]  code_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pce_pkg::ByteW-1:0]    out_byte_o,
  output logic                         out_last_o
);
  import pce_pkg::*;

  localparam int LenW   = $clog2(CodeW + 1);
  localparam int EntryW = LenW + CodeW;
  localparam int Depth  = 1 << SymW;

  // Code table: length in the upper bits, code word in the lower bits.
  logic [EntryW-1:0] tbl_mem [Depth];
  logic [EntryW-1:0] rd_q;
  logic [LenW-1:0]   wr_len;
  logic [LenW-1:0]   rd_len;
  logic [CodeW-1:0]  rd_word;
  logic [LenW-1:0]   align_sh;

  // Packer state
  logic [CodeW-1:0] sh_q, sh_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [7:0]       pend_q, pend_d;
  logic [2:0]       pos_q, pos_d;

  logic [3:0]      free;
  logic [3:0]      nbits;
  logic [LenW-1:0] rem_after;
  logic [7:0]      top8;
  logic [7:0]      merged;
  logic            full;

  // Output register
  logic            ovld_q, ovld_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;
  logic            slot_free;

  // Saturate loaded length at the table's code width.
  assign wr_len = (code_length_i > InLenW'(CodeW)) ? LenW'(CodeW)
                                                   : LenW'(code_length_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) tbl_mem[symbol_i] <= {wr_len, code_word_i[CodeW-1:0]};
    if (cmd_i.tbl_rd) rd_q <= tbl_mem[symbol_i];
  end

  assign rd_len   = rd_q[EntryW-1 -: LenW];
  assign rd_word  = rd_q[CodeW-1:0];
  // Left-align so the earliest code bit sits at the MSB; unused bits shift out.
  assign align_sh = LenW'(CodeW) - rd_len;

  assign free      = {1'b0, pos_q} + 4'd1;
  assign full      = ({{(8 - LenW){1'b0}}, rem_q} >= {4'd0, free});
  assign nbits     = full ? free : rem_q[3:0];
  assign rem_after = rem_q - LenW'(nbits);
  assign top8      = sh_q[CodeW-1 -: 8];
  assign merged    = pend_q | (top8 >> (3'd7 - pos_q));
  assign slot_free = !ovld_q || out_ready_i;

  assign sts_o.code_done  = (rem_q == '0);
  assign sts_o.last_step  = ({{(8 - LenW){1'b0}}, rem_q} <= {4'd0, free});
  assign sts_o.byte_full  = full;
  assign sts_o.pend_empty = (pos_q == EmptyPos);
  assign sts_o.slot_free  = slot_free;

  always_comb begin
    sh_d    = sh_q;
    rem_d   = rem_q;
    pend_d  = pend_q;
    pos_d   = pos_q;
    ovld_d  = ovld_q && !out_ready_i;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (cmd_i.code_ld) begin
      sh_d  = rd_word << align_sh;
      rem_d = rd_len;
    end
    if (cmd_i.pack_step) begin
      sh_d  = sh_q << nbits;
      rem_d = rem_after;
      if (full) begin
        pend_d  = '0;
        pos_d   = EmptyPos;
        ovld_d  = 1'b1;
        obyte_d = merged;
        // Final byte of this item unless another full byte still follows.
        olast_d = ({{(8 - LenW){1'b0}}, rem_after} < 8'd8);
      end else begin
        pend_d = merged;
        pos_d  = pos_q - nbits[2:0];
      end
    end
    if (cmd_i.flush_pend) begin
      ovld_d  = 1'b1;
      obyte_d = pend_q;
      olast_d = 1'b0;
    end
    if (cmd_i.emit_mark) begin
      ovld_d  = 1'b1;
      obyte_d = {5'd0, pos_q};
      olast_d = 1'b1;
      pend_d  = '0;
      pos_d   = EmptyPos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      pend_q <= '0;
      pos_q  <= EmptyPos;
      ovld_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      pend_q <= pend_d;
      pos_q  <= pos_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

// File: rtl/core/prefix_code_byte_encoder_unit.sv
// Top level of the prefix-code byte encoder: controller plus datapath.
//
// Channel | Dir | Transfer content
// --------+-----+---------------------------------------------------------------
// s_axis  | in  | tuser: kind; tdata: symbol, code_length, code_word
// m_axis  | out | tdata: out_byte; tlast: last_of_run
//
// Steps: a load writes its table entry on accept. An encode accepts and reads
// the table into a register, loads the packer, then moves one chunk of code bits
// per step, a chunk ending at each byte boundary. A finish accepts, emits the
// partial byte if any bits are pending, then emits the marker byte.
// The packer moves at most one output byte per cycle unless the output stalls.
// Reset: rst_ni clears the packer (marker position 7, no pending bits) and the
// output register; the code table is not cleared and must be loaded first.
// Stalls: the output register holds one byte; the block waits while it is
// full and not taken, and takes a new input only when the previous item is done.
module prefix_code_byte_encoder_unit #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] symbol, [13:8] code_length, [45:14] code_word, [47:46] zero
  input  logic [pce_pkg::InDataW-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  import pce_pkg::*;

  // Code word storage never exceeds the 32-bit input field.
  localparam int CodeW = (MAX_CODE_BITS > InWordW) ? InWordW : MAX_CODE_BITS;

  pce_cmd_t cmd;
  pce_sts_t sts;

  pce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pce_dpath #(
    .CodeW (CodeW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .symbol_i      (s_axis_tdata[7:0]),
    .code_length_i (s_axis_tdata[13:8]),
    .code_word_i   (s_axis_tdata[45:14]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule
